// ===== rtl/core/bdq_pkg.sv =====
package bdq_pkg;

  // Width of one stored word.
  localparam int unsigned WORD_W = 32;

  // Operation codes carried by an input item.
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_READ_POS   = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  // What a cell loads at the next clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_TAKE_LEFT  = 2'd1,
    CELL_TAKE_RIGHT = 2'd2,
    CELL_LOAD       = 2'd3
  } cell_cmd_t;

  // Control bundle sent from the queue controller to each cell.
  typedef struct packed {
    cell_cmd_t cmd;
    logic      rd_sel;
  } cell_ctl_t;

endpackage

// ===== rtl/core/bounded_double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit words, held in a row of DEPTH
// cells with the front word always in the first cell. Each item (push front,
// push back, pop front, pop back, read at a position from the front) is
// accepted when it is started, so busy is always low and an item may be started
// every cycle. Its result appears on the out_ ports in the cycle after the item
// is accepted and is marked by out_valid for exactly one cycle; the receiver
// cannot stall it and must take it then. The cell row makes this possible:
// a front push or pop shifts every cell by one position at once, and reads
// go through a one-hot OR bus over the cells.
module bounded_double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_opcode,
  input  logic signed [bdq_pkg::WORD_W-1:0] in_push_value,
  input  logic [3:0]                        in_position,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic signed [bdq_pkg::WORD_W-1:0] out_value_out,
  output logic [4:0]                        out_fill_count
);
  import bdq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > 4) ? CW : 4;

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [WORD_W-1:0] out_value_r;
  logic [4:0]        out_fill_r;

  logic [1:0]        status_nxt;
  logic              accept;
  logic              is_full;
  logic              is_empty;
  logic              do_push_front;
  logic              do_push_back;
  logic              do_pop_front;
  logic              do_pop_back;
  logic              do_read;
  logic [CW-1:0]     last_idx;
  logic [PW-1:0]     pos_ext;
  logic [WORD_W-1:0] rd_word;

  cell_ctl_t         ctl     [DEPTH];
  logic [WORD_W-1:0] cell_q  [DEPTH];
  logic [WORD_W-1:0] cell_rd [DEPTH];

  assign busy     = 1'b0;
  assign accept   = start;
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);
  assign last_idx = count_r - CW'(1);
  assign pos_ext  = PW'(in_position);

  // Decode the operation and work out status and the new count.
  always_comb begin
    do_push_front = 1'b0;
    do_push_back  = 1'b0;
    do_pop_front  = 1'b0;
    do_pop_back   = 1'b0;
    do_read       = 1'b0;
    status_nxt    = ST_OK;
    count_nxt     = count_r;
    case (in_opcode)
      OP_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          do_push_front = accept;
          count_nxt     = count_r + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          do_push_back = accept;
          count_nxt    = count_r + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          do_pop_front = accept;
          count_nxt    = count_r - CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          do_pop_back = accept;
          count_nxt   = count_r - CW'(1);
        end
      end
      OP_READ_POS: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else if (pos_ext >= PW'(count_r)) begin
          status_nxt = ST_BADPOS;
        end else begin
          do_read = accept;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Per-cell commands: shift toward the back on a front push, toward the
  // front on a front pop, load in place on a back push, and set the read select.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_comb begin
      if (do_push_front) begin
        ctl[i].cmd = CELL_TAKE_LEFT;
      end else if (do_pop_front) begin
        ctl[i].cmd = CELL_TAKE_RIGHT;
      end else if (do_push_back && (CW'(i) == count_r)) begin
        ctl[i].cmd = CELL_LOAD;
      end else begin
        ctl[i].cmd = CELL_HOLD;
      end
      ctl[i].rd_sel = (do_pop_front && (i == 0)) ||
                      (do_pop_back && (CW'(i) == last_idx)) ||
                      (do_read && (PW'(i) == pos_ext));
    end

    bdq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[i]),
      .left_in  ((i == 0) ? WORD_W'(in_push_value) : cell_q[(i == 0) ? 0 : i - 1]),
      .right_in ((i == DEPTH - 1) ? cell_q[i] : cell_q[(i == DEPTH - 1) ? i : i + 1]),
      .load_in  (WORD_W'(in_push_value)),
      .data     (cell_q[i]),
      .rd_data  (cell_rd[i])
    );
  end

  // Collect the selected word from the read bus.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  // Occupancy and the result strobe are control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_nxt;
      out_value_r  <= rd_word;
      out_fill_r   <= 5'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_value_out  = out_value_r;
  assign out_fill_count = out_fill_r;

endmodule

// ===== rtl/core/bdq_cell.sv =====
module bdq_cell (
  input  logic                        clk,
  input  bdq_pkg::cell_ctl_t          ctl,
  input  logic [bdq_pkg::WORD_W-1:0]  left_in,
  input  logic [bdq_pkg::WORD_W-1:0]  right_in,
  input  logic [bdq_pkg::WORD_W-1:0]  load_in,
  output logic [bdq_pkg::WORD_W-1:0]  data,
  output logic [bdq_pkg::WORD_W-1:0]  rd_data
);
  import bdq_pkg::*;

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;

  // Pick the word this cell holds after the edge.
  always_comb begin
    case (ctl.cmd)
      CELL_HOLD:       data_nxt = data_r;
      CELL_TAKE_LEFT:  data_nxt = left_in;
      CELL_TAKE_RIGHT: data_nxt = right_in;
      CELL_LOAD:       data_nxt = load_in;
      default:         data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  // The read bus is an OR of all cells, so an unselected cell drives zero.
  assign rd_data = ctl.rd_sel ? data_r : '0;

endmodule
